// ===== hw/rtl/lsq_pkg.sv =====
// ----------------------------------------------------------------------------
// lsq_pkg
// Shared types, constants and step helpers for the light seek sequencer.
// ----------------------------------------------------------------------------
package lsq_pkg;

   localparam int unsigned LIGHT_W = 10;
   localparam int unsigned PAN_W   = 8;
   localparam int unsigned TILT_W  = 7;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned CSR_W   = 10;

   localparam logic [PAN_W-1:0]  PAN_MAX  = 8'd180;
   localparam logic [TILT_W-1:0] TILT_MAX = 7'd90;

   localparam logic [LIGHT_W-1:0] THRESHOLD_RESET = 10'd20;
   localparam logic [TILT_W-1:0]  SCAN_TILT_RESET = 7'd55;

   typedef enum logic [0:0] {
      CSR_IDX_THRESHOLD = 1'b0,
      CSR_IDX_SCAN_TILT = 1'b1
   } csr_idx_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_MONITOR    = 3'd0,
      PH_HOME_PAN   = 3'd1,
      PH_TILT_SCAN  = 3'd2,
      PH_PAN_SWEEP  = 3'd3,
      PH_PAN_BEST   = 3'd4,
      PH_TILT_ZERO  = 3'd5,
      PH_TILT_SWEEP = 3'd6,
      PH_TILT_BEST  = 3'd7
   } phase_type;

   typedef struct packed {
      phase_type           phase;
      logic [PAN_W-1:0]    pan;
      logic [TILT_W-1:0]   tilt;
      logic [PAN_W-1:0]    best_pan;
      logic [TILT_W-1:0]   best_tilt;
      logic [LIGHT_W-1:0]  peak;
      logic [LIGHT_W-1:0]  reference;
   } seek_state_type;

   function automatic logic [PAN_W-1:0] step_pan(
      input logic [PAN_W-1:0] pos,
      input logic [PAN_W-1:0] target
   );
      logic [PAN_W-1:0] res;
      if (pos < target) begin
         res = pos + 8'd1;
      end else if (pos > target) begin
         res = pos - 8'd1;
      end else begin
         res = pos;
      end
      return res;
   endfunction

   function automatic logic [TILT_W-1:0] step_tilt(
      input logic [TILT_W-1:0] pos,
      input logic [TILT_W-1:0] target
   );
      logic [TILT_W-1:0] res;
      if (pos < target) begin
         res = pos + 7'd1;
      end else if (pos > target) begin
         res = pos - 7'd1;
      end else begin
         res = pos;
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/lsq_tick.sv =====
// ----------------------------------------------------------------------------
// lsq_tick
// Next-state logic for one light sample: monitor compare, axis steps, sweeps.
// ----------------------------------------------------------------------------
module lsq_tick (
   input  lsq_pkg::seek_state_type         cur,
   input  logic [lsq_pkg::LIGHT_W-1:0]     light,
   input  logic [lsq_pkg::LIGHT_W-1:0]     threshold,
   input  logic [lsq_pkg::TILT_W-1:0]      scan_tilt,
   output lsq_pkg::seek_state_type         nxt,
   output logic                            done
);
   import lsq_pkg::*;

   logic [TILT_W-1:0]  tilt_target;
   logic [LIGHT_W-1:0] diff;
   logic [PAN_W-1:0]   pan_step;
   logic [TILT_W-1:0]  tilt_step;

   assign tilt_target = (scan_tilt > TILT_MAX) ? TILT_MAX : scan_tilt;
   assign diff = (light > cur.reference) ? (light - cur.reference)
                                         : (cur.reference - light);

   always_comb begin
      nxt       = cur;
      done      = 1'b0;
      pan_step  = cur.pan;
      tilt_step = cur.tilt;
      case (cur.phase)
         PH_MONITOR: begin
            if (diff > threshold) begin
               nxt.phase = PH_HOME_PAN;
            end
         end
         PH_HOME_PAN: begin
            pan_step = step_pan(cur.pan, '0);
            nxt.pan  = pan_step;
            if (pan_step == '0) begin
               nxt.phase = PH_TILT_SCAN;
            end
         end
         PH_TILT_SCAN: begin
            tilt_step = step_tilt(cur.tilt, tilt_target);
            nxt.tilt  = tilt_step;
            if (tilt_step == tilt_target) begin
               nxt.phase    = PH_PAN_SWEEP;
               nxt.peak     = '0;
               nxt.best_pan = '0;
            end
         end
         PH_PAN_SWEEP: begin
            if (light > cur.peak) begin
               nxt.peak     = light;
               nxt.best_pan = cur.pan;
            end
            if (cur.pan < PAN_MAX) begin
               nxt.pan = cur.pan + 8'd1;
            end else begin
               nxt.phase = PH_PAN_BEST;
            end
         end
         PH_PAN_BEST: begin
            pan_step = step_pan(cur.pan, cur.best_pan);
            nxt.pan  = pan_step;
            if (pan_step == cur.best_pan) begin
               nxt.phase = PH_TILT_ZERO;
            end
         end
         PH_TILT_ZERO: begin
            tilt_step = step_tilt(cur.tilt, '0);
            nxt.tilt  = tilt_step;
            if (tilt_step == '0) begin
               nxt.phase     = PH_TILT_SWEEP;
               nxt.peak      = '0;
               nxt.best_tilt = '0;
            end
         end
         PH_TILT_SWEEP: begin
            if (light > cur.peak) begin
               nxt.peak      = light;
               nxt.best_tilt = cur.tilt;
            end
            if (cur.tilt < TILT_MAX) begin
               nxt.tilt = cur.tilt + 7'd1;
            end else begin
               nxt.phase = PH_TILT_BEST;
            end
         end
         PH_TILT_BEST: begin
            tilt_step = step_tilt(cur.tilt, cur.best_tilt);
            nxt.tilt  = tilt_step;
            if (tilt_step == cur.best_tilt) begin
               nxt.reference = cur.peak;
               nxt.phase     = PH_MONITOR;
               done          = 1'b1;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// ===== hw/rtl/two_axis_light_seek_sequencer.sv =====
// ----------------------------------------------------------------------------
// two_axis_light_seek_sequencer
// Pan/tilt light seeking sequencer: one light sample in, one angle word out.
// Path: an accepted req word waits in the input register, then the
// combinational tick logic updates all state and the result register loads.
// Throughput: 1 word per cycle unless rsp_tready stalls the output.
// Reset: synchronous; starts scanning from pan 0, tilt 90, reference 0,
// threshold 20, scan tilt 55.
// ----------------------------------------------------------------------------
module two_axis_light_seek_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [9:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // light_level[9:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // pan_angle[7:0], tilt_angle[14:8],
                                   // phase_now[17:15], reference_out[27:18]
   output logic        rsp_tlast   // scan_done
);
   import lsq_pkg::*;

   logic [LIGHT_W-1:0] threshold_ff;
   logic [TILT_W-1:0]  scan_tilt_ff;
   seek_state_type     state_ff;
   seek_state_type     state_in;
   logic               in_valid_ff;
   logic [LIGHT_W-1:0] light_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic [31:0]        rsp_data_in;
   logic               rsp_last_ff;
   logic               done;
   logic               fire;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   lsq_tick u_tick (
      .cur       (state_ff),
      .light     (light_ff),
      .threshold (threshold_ff),
      .scan_tilt (scan_tilt_ff),
      .nxt       (state_in),
      .done      (done)
   );

   assign rsp_data_in = {4'd0, state_in.reference, state_in.phase,
                         state_in.tilt, state_in.pan};

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         scan_tilt_ff <= SCAN_TILT_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_IDX_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_IDX_SCAN_TILT: scan_tilt_ff <= csr_wdata[TILT_W-1:0];
            default: begin
               threshold_ff <= threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_HOME_PAN, pan: '0, tilt: TILT_MAX,
                       best_pan: '0, best_tilt: '0, peak: '0, reference: '0};
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         light_ff <= req_tdata[LIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.pan <= PAN_MAX) && (state_ff.tilt <= TILT_MAX))
      else $error("axis position out of range");

   a_done_monitor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_data_ff[17:15] == PH_MONITOR))
      else $error("scan done without return to monitor");

   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed sample produced no result");

   a_monitor_hold: assert property (@(posedge clock) disable iff (reset)
      (fire && (state_ff.phase == PH_MONITOR)) |=>
      ((state_ff.pan == $past(state_ff.pan)) && (state_ff.tilt == $past(state_ff.tilt))))
      else $error("axis moved in monitor");
`endif

endmodule
